[rtl/dqr_pkg.sv]
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types and codes for the double-ended queue cell row.
// ----------------------------------------------------------------------------
package dqr_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell for one accepted beat.
  typedef struct packed {
    logic  apply;
    op_t   op;
    data_t value;
  } cell_cmd_t;

endpackage

[rtl/dqr_cell.sv]
// ----------------------------------------------------------------------------
// dqr_cell
// One entry of the deque row. The front sits at cell 0 and occupied cells
// form an unbroken run from there; front operations shift the row, rear
// operations act on the boundary cell alone.
// ----------------------------------------------------------------------------
module dqr_cell
  import dqr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  data_t     left_data,
  input  logic      left_occ,
  input  data_t     right_data,
  input  logic      right_occ,
  output data_t     data,
  output logic      occ,
  output logic      rear
);

  data_t data_next;
  logic  occ_next;

  assign rear = occ & ~right_occ;

  always_comb begin
    data_next = data;
    occ_next  = occ;
    if (cmd.apply) begin
      unique case (cmd.op)
        OP_PUSH_FRONT: begin
          data_next = left_data;
          occ_next  = left_occ;
        end
        OP_POP_FRONT: begin
          data_next = right_data;
          occ_next  = right_occ;
        end
        OP_PUSH_REAR: begin
          if (!occ && left_occ) begin
            data_next = cmd.value;
            occ_next  = 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (rear) begin
            occ_next = 1'b0;
          end
        end
        default: begin
          occ_next = occ;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule

[rtl/double_ended_queue_ring_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_ring_core
// Double-ended queue of DEPTH signed 32-bit entries held in a row of cells.
//
// Input channel (in_valid/in_ready): opcode and push_value; pushes at either
// end, pops from either end. Output channel (out_valid/out_ready): one beat
// per input beat with status, popped_value, is_full and is_empty after the
// operation. A refused push (full) or pop (empty) leaves the contents as they
// were; a refused pop returns 0.
// The result is registered on the edge that takes the input beat and offered
// from the next cycle. Throughput is one beat per cycle while out_ready is
// held high, set by the update of the whole cell row together and the
// rear-entry select across it.
// A stalled receiver holds the result register; in_ready is low until that
// beat is taken, and no input is lost.
// Reset clears every occupancy bit at once: the deque is empty and the first
// input beat may follow straight away. Entry data is not reset.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_core
  import dqr_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic signed [31:0] push_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic signed [31:0] popped_value,
  output logic              is_full,
  output logic              is_empty
);

  data_t       cell_data [DEPTH];
  logic [DEPTH-1:0] cell_occ;
  logic [DEPTH-1:0] cell_rear;

  cell_cmd_t   cmd;
  op_t         op;
  logic        accept;
  logic        full_now;
  logic        empty_now;
  logic        refused;
  data_t       rear_data;

  status_t     status_reg;
  status_t     status_next;
  data_t       popped_reg;
  data_t       popped_next;
  logic        full_reg;
  logic        full_next;
  logic        empty_reg;
  logic        empty_next;

  assign op        = op_t'(opcode);
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign full_now  = cell_occ[DEPTH-1];
  assign empty_now = !cell_occ[0];

  always_comb begin
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: refused = full_now;
      OP_POP_FRONT, OP_POP_REAR:   refused = empty_now;
      default:                     refused = 1'b1;
    endcase
  end

  assign cmd.apply = accept && !refused;
  assign cmd.op    = op;
  assign cmd.value = push_value;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      data_t left_data;
      logic  left_occ;
      data_t right_data;
      logic  right_occ;
      if (i == 0) begin : g_first
        assign left_data = push_value;
        assign left_occ  = 1'b1;
      end else begin : g_inner_l
        assign left_data = cell_data[i-1];
        assign left_occ  = cell_occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_data = '0;
        assign right_occ  = 1'b0;
      end else begin : g_inner_r
        assign right_data = cell_data[i+1];
        assign right_occ  = cell_occ[i+1];
      end
      dqr_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .left_data  (left_data),
        .left_occ   (left_occ),
        .right_data (right_data),
        .right_occ  (right_occ),
        .data       (cell_data[i]),
        .occ        (cell_occ[i]),
        .rear       (cell_rear[i])
      );
    end
  endgenerate

  // at most one rear flag is set
  always_comb begin
    rear_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rear_data = rear_data | (cell_rear[k] ? cell_data[k] : '0);
    end
  end

  always_comb begin
    status_next = ST_DONE;
    popped_next = '0;
    full_next   = full_now;
    empty_next  = empty_now;
    unique case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full_now) begin
          status_next = ST_FULL;
        end else begin
          full_next  = cell_occ[DEPTH-2];
          empty_next = 1'b0;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty_now) begin
          status_next = ST_EMPTY;
        end else begin
          popped_next = (op == OP_POP_FRONT) ? cell_data[0] : rear_data;
          full_next   = 1'b0;
          empty_next  = !cell_occ[1];
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_reg <= status_next;
      popped_reg <= popped_next;
      full_reg   <= full_next;
      empty_reg  <= empty_next;
    end
  end

  assign status       = status_reg;
  assign popped_value = popped_reg;
  assign is_full      = full_reg;
  assign is_empty     = empty_reg;

endmodule
